[rtl/spm_pkg.sv]
// shared types and constants for the splitmix pattern generator and checker
package spm_pkg;

    // command codes of an input request
    localparam logic [1:0] CMD_GENERATE = 2'd0;
    localparam logic [1:0] CMD_CHECK    = 2'd1;
    localparam logic [1:0] CMD_RESTART  = 2'd2;

    // field widths
    localparam int WORD_W   = 64;
    localparam int INDEX_W  = 30;
    localparam int REGION_W = 14;
    localparam int MIB_SHIFT = 17;  // 131072 words of 64 bits per MiB

    // splitmix64 constants
    localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [WORD_W-1:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
    localparam logic [WORD_W-1:0] MIX_MUL_B    = 64'h94d049bb133111eb;
    localparam int SHIFT_1 = 30;
    localparam int SHIFT_2 = 27;
    localparam int SHIFT_3 = 31;

    // operation classes handed from front to back
    typedef enum logic [1:0] {
        OP_GENERATE,
        OP_CHECK,
        OP_RESTART
    } op_t;

    // input request payload
    typedef struct packed {
        logic [1:0]        command;
        logic [WORD_W-1:0] read_word;
    } item_t;

    // result payload
    typedef struct packed {
        logic [WORD_W-1:0]  pattern_word;
        logic [INDEX_W-1:0] word_index;
        logic               mismatch;
        logic               error_seen;
        logic [INDEX_W-1:0] first_error_index;
        logic               end_of_region;
    } result_t;

    // classified work in the queue between front and back
    typedef struct packed {
        op_t                op;
        logic [INDEX_W-1:0] index;
        logic               last;
        logic [WORD_W-1:0]  read_word;
    } job_t;

endpackage

[rtl/splitmix_pattern_generator_checker.sv]
// top level of the splitmix64 storage test pattern generator and checker
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_data) sets the region size in MiB;
//   a zero size acts as 1 and sizes above MAX_REGION_MIB are clamped.
//   Write it only while the block is idle. cfg_ready is always high.
//   item channel takes a request: generate, check (with read_word) or restart.
//   Generate and check each answer with one result on the result channel;
//   restart and the unused command answer with nothing.
// Timing:
//   one request per cycle sustained while result_ready stays high; a result passes
//   through the queue slot, four mixer stages with the 64-bit multiplies
//   split into 32-bit partial products, and the output register.
// Reset:
//   index, error latch and first error index clear, region size returns to 1.
// Stall:
//   when a result waits and result_ready is low the mixer pipe freezes; the
//   two-entry queue keeps taking requests until full, then item_ready drops.
module splitmix_pattern_generator_checker
    import spm_pkg::*;
#(
    parameter int MAX_REGION_MIB = 8192
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [REGION_W-1:0] cfg_data,
    input  logic                item_valid,
    output logic                item_ready,
    input  item_t               item,
    output logic                result_valid,
    input  logic                result_ready,
    output result_t             result
);

    logic push;
    job_t push_job;
    logic full;
    logic pop;
    job_t pop_job;
    logic empty;

    // request intake and index walk
    spm_front #(
        .MAX_REGION_MIB (MAX_REGION_MIB)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .push       (push),
        .push_job   (push_job),
        .full       (full)
    );

    // decoupling queue
    spm_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (empty)
    );

    // mixer, compare and error latch
    spm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop          (pop),
        .pop_job      (pop_job),
        .empty        (empty),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

[rtl/spm_fifo.sv]
// two-entry queue of classified jobs between front and back
module spm_fifo
    import spm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t pop_job,
    output logic empty
);

    job_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    // status
    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = slot_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[rtl/spm_front.sv]
// front end: accepts requests, walks the word index and classifies work
module spm_front
    import spm_pkg::*;
#(
    parameter int MAX_REGION_MIB = 8192
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [REGION_W-1:0] cfg_data,
    input  logic                item_valid,
    output logic                item_ready,
    input  item_t               item,
    output logic                push,
    output job_t                push_job,
    input  logic                full
);

    logic [INDEX_W-1:0]  index_reg;
    logic [INDEX_W-1:0]  index_next;
    logic [INDEX_W-1:0]  last_reg;
    logic [INDEX_W-1:0]  last_next;
    logic [REGION_W-1:0] mib_eff;
    logic [REGION_W-1:0] mib_m1;
    logic                accept;
    logic                is_last;

    assign cfg_ready  = 1'b1;
    assign item_ready = !full;
    assign accept     = item_valid && item_ready;

    // clamp the region size and turn it into the last word index
    always_comb
    begin
        mib_eff = cfg_data;
        if (cfg_data == '0)
        begin
            mib_eff = REGION_W'(1);
        end
        else if (cfg_data > REGION_W'(MAX_REGION_MIB))
        begin
            mib_eff = REGION_W'(MAX_REGION_MIB);
        end
        mib_m1    = mib_eff - REGION_W'(1);
        last_next = last_reg;
        if (cfg_valid)
        begin
            last_next = {mib_m1[INDEX_W-MIB_SHIFT-1:0], {MIB_SHIFT{1'b1}}};
        end
    end

    // classify the request and advance or clear the index
    always_comb
    begin
        is_last            = (index_reg >= last_reg);
        index_next         = index_reg;
        push               = 1'b0;
        push_job.op        = OP_GENERATE;
        push_job.index     = index_reg;
        push_job.last      = is_last;
        push_job.read_word = item.read_word;
        case (item.command)
            CMD_GENERATE,
            CMD_CHECK:
            begin
                push        = accept;
                push_job.op = (item.command == CMD_CHECK) ? OP_CHECK : OP_GENERATE;
                if (accept)
                begin
                    index_next = is_last ? '0 : index_reg + INDEX_W'(1);
                end
            end
            CMD_RESTART:
            begin
                push        = accept;
                push_job.op = OP_RESTART;
                if (accept)
                begin
                    index_next = '0;
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg <= '0;
            last_reg  <= {{(INDEX_W-MIB_SHIFT){1'b0}}, {MIB_SHIFT{1'b1}}};
        end
        else
        begin
            index_reg <= index_next;
            last_reg  <= last_next;
        end
    end

endmodule

[rtl/spm_back.sv]
// back end: pipelined splitmix64 mixer, compare and error latch
module spm_back
    import spm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    output logic    pop,
    input  job_t    pop_job,
    input  logic    empty,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    localparam int HALF_W = WORD_W / 2;

    // stage valid bits
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic s4_valid_reg;
    logic out_valid_reg;
    logic out_valid_next;
    logic advance;

    // stage payload
    job_t               s1_job_reg;
    job_t               s2_job_reg;
    job_t               s3_job_reg;
    job_t               s4_job_reg;
    logic [WORD_W-1:0]  s1_mix_reg;
    logic [WORD_W-1:0]  s2_ll_reg;
    logic [HALF_W-1:0]  s2_lh_reg;
    logic [HALF_W-1:0]  s2_hl_reg;
    logic [WORD_W-1:0]  s3_mix_reg;
    logic [WORD_W-1:0]  s4_ll_reg;
    logic [HALF_W-1:0]  s4_lh_reg;
    logic [HALF_W-1:0]  s4_hl_reg;
    result_t            out_reg;
    result_t            out_next;

    // error latch
    logic               latch_reg;
    logic               latch_next;
    logic [INDEX_W-1:0] first_reg;
    logic [INDEX_W-1:0] first_next;

    // combinational stage values
    logic [WORD_W-1:0]  s0_sum;
    logic [WORD_W-1:0]  s0_mix;
    logic [WORD_W-1:0]  s2_prod;
    logic [WORD_W-1:0]  s2_mix;
    logic [WORD_W-1:0]  s4_prod;
    logic [WORD_W-1:0]  pattern;
    logic               bad;

    // whole pipe moves unless a finished result waits
    assign advance      = !out_valid_reg || result_ready;
    assign pop          = advance && !empty;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // add gamma and first xor-shift
    assign s0_sum = WORD_W'(pop_job.index) + GOLDEN_GAMMA;
    assign s0_mix = s0_sum ^ (s0_sum >> SHIFT_1);

    // finish first multiply, second xor-shift
    assign s2_prod = s2_ll_reg + {HALF_W'(s2_lh_reg + s2_hl_reg), {HALF_W{1'b0}}};
    assign s2_mix  = s2_prod ^ (s2_prod >> SHIFT_2);

    // finish second multiply, final xor-shift
    assign s4_prod = s4_ll_reg + {HALF_W'(s4_lh_reg + s4_hl_reg), {HALF_W{1'b0}}};
    assign pattern = s4_prod ^ (s4_prod >> SHIFT_3);

    // compare and update the error latch
    always_comb
    begin
        bad        = (s4_job_reg.op == OP_CHECK) && (s4_job_reg.read_word != pattern);
        latch_next = latch_reg;
        first_next = first_reg;
        out_next   = out_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = s4_valid_reg && (s4_job_reg.op != OP_RESTART);
            if (s4_valid_reg)
            begin
                if (s4_job_reg.op == OP_RESTART)
                begin
                    latch_next = 1'b0;
                    first_next = '0;
                end
                else if (bad && !latch_reg)
                begin
                    latch_next = 1'b1;
                    first_next = s4_job_reg.index;
                end
            end
            out_next.pattern_word      = pattern;
            out_next.word_index        = s4_job_reg.index;
            out_next.mismatch          = bad;
            out_next.error_seen        = latch_next;
            out_next.first_error_index = first_next;
            out_next.end_of_region     = s4_job_reg.last;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            latch_reg     <= 1'b0;
            first_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            latch_reg     <= latch_next;
            first_reg     <= first_next;
            if (advance)
            begin
                s1_valid_reg <= !empty;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    // payload registers, partial products split into 32-bit multipliers
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (advance)
        begin
            s1_job_reg <= pop_job;
            s1_mix_reg <= s0_mix;

            s2_job_reg <= s1_job_reg;
            s2_ll_reg  <= WORD_W'(s1_mix_reg[HALF_W-1:0]) * WORD_W'(MIX_MUL_A[HALF_W-1:0]);
            s2_lh_reg  <= HALF_W'(s1_mix_reg[HALF_W-1:0] * MIX_MUL_A[WORD_W-1:HALF_W]);
            s2_hl_reg  <= HALF_W'(s1_mix_reg[WORD_W-1:HALF_W] * MIX_MUL_A[HALF_W-1:0]);

            s3_job_reg <= s2_job_reg;
            s3_mix_reg <= s2_mix;

            s4_job_reg <= s3_job_reg;
            s4_ll_reg  <= WORD_W'(s3_mix_reg[HALF_W-1:0]) * WORD_W'(MIX_MUL_B[HALF_W-1:0]);
            s4_lh_reg  <= HALF_W'(s3_mix_reg[HALF_W-1:0] * MIX_MUL_B[WORD_W-1:HALF_W]);
            s4_hl_reg  <= HALF_W'(s3_mix_reg[WORD_W-1:HALF_W] * MIX_MUL_B[HALF_W-1:0]);
        end
    end

endmodule
